// ===== src/lbdc_pkg.sv =====
// shared types and constants for the line buffer depth and capacity unit
`default_nettype none
package lbdc_pkg;

   localparam int BPP_W     = 6;
   localparam int WIDTH_W   = 14;
   localparam int DEPTH_W   = 2;
   localparam int CAPS_W    = 4;
   localparam int PITCH_W   = 13;
   localparam int LINES_W   = 11;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 4;

   localparam logic [LINES_W-1:0] LINE_COUNT_MAX = 11'd2047;

   // display depths with a dedicated code
   localparam logic [BPP_W-1:0] BPP_18 = 6'd18;
   localparam logic [BPP_W-1:0] BPP_24 = 6'd24;
   localparam logic [BPP_W-1:0] BPP_36 = 6'd36;
   localparam logic [BPP_W-1:0] BPP_42 = 6'd42;
   localparam logic [BPP_W-1:0] BPP_48 = 6'd48;

   // storage depth codes
   localparam logic [DEPTH_W-1:0] DEPTH_18 = 2'd0;
   localparam logic [DEPTH_W-1:0] DEPTH_24 = 2'd1;
   localparam logic [DEPTH_W-1:0] DEPTH_30 = 2'd2;
   localparam logic [DEPTH_W-1:0] DEPTH_36 = 2'd3;

   // pitch rounding coefficients
   localparam logic [9:0] COEF_24 = 10'd683;
   localparam logic [9:0] COEF_30 = 10'd854;
   localparam logic [8:0] ROUND_ADD = 9'd511;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DEPTH_CAPS    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_DEPTH = 1'd1;

   localparam logic [CAPS_W-1:0]  CAPS_RESET    = 4'd4;
   localparam logic [DEPTH_W-1:0] DEFAULT_RESET = DEPTH_30;

   // classified item handed from front to back
   typedef struct packed {
      logic [DEPTH_W-1:0] depth;
      logic [PITCH_W-1:0] pitch;
      logic               fits;
   } lbdc_item_type;

   // queue head as seen by the back end
   typedef struct packed {
      logic          valid;
      lbdc_item_type item;
   } lbdc_head_type;

endpackage
`default_nettype wire

// ===== src/lbdc_front.sv =====
// front end: depth selection, pitch and fit check for one request beat
`default_nettype none
module lbdc_front
   import lbdc_pkg::*;
#(
   parameter int TOTAL_ENTRIES = 1712
) (
   input  wire logic [CAPS_W-1:0]  depth_caps,
   input  wire logic [DEPTH_W-1:0] default_depth,
   input  wire logic [BPP_W-1:0]   color_depth,
   input  wire logic [WIDTH_W-1:0] active_pixels,
   output lbdc_item_type           item
);

   logic [DEPTH_W-1:0] want;
   logic [DEPTH_W-1:0] depth;
   logic [WIDTH_W:0]   sum8;
   logic [WIDTH_W:0]   sum4;
   logic [11:0]        groups;
   logic [9:0]         coef;
   logic [21:0]        prod;
   logic [21:0]        rounded;
   logic [PITCH_W-1:0] pitch;

   always_comb begin
      unique case (color_depth)
         BPP_18:                 want = DEPTH_18;
         BPP_24:                 want = DEPTH_24;
         BPP_36, BPP_42, BPP_48: want = DEPTH_36;
         default:                want = DEPTH_30;
      endcase
   end

   // smallest allowed code at or above the wanted one, else the default depth
   always_comb begin
      depth = default_depth;
      for (int c = CAPS_W - 1; c >= 0; c--) begin
         if (DEPTH_W'(c) >= want && depth_caps[c]) begin
            depth = DEPTH_W'(c);
         end
      end
   end

   assign sum8    = {1'b0, active_pixels} + (WIDTH_W+1)'(7);
   assign sum4    = {1'b0, active_pixels} + (WIDTH_W+1)'(3);
   assign groups  = sum8[WIDTH_W:3];
   assign coef    = (depth == DEPTH_24) ? COEF_24 : COEF_30;
   assign prod    = 22'(groups) * 22'(coef);
   assign rounded = prod + 22'(ROUND_ADD);

   always_comb begin
      unique case (depth)
         DEPTH_18: pitch = PITCH_W'(groups);
         DEPTH_24,
         DEPTH_30: pitch = rounded[PITCH_W+8:9];
         default:  pitch = sum4[WIDTH_W:2];
      endcase
   end

   assign item.depth = depth;
   assign item.pitch = pitch;
   assign item.fits  = (active_pixels != '0) && (pitch != '0)
                       && (pitch <= PITCH_W'(TOTAL_ENTRIES));

endmodule
`default_nettype wire

// ===== src/lbdc_queue.sv =====
// two-entry queue between front end and divider back end
`default_nettype none
module lbdc_queue
   import lbdc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire lbdc_item_type push_item,
   output logic               full,
   input  wire logic          pop,
   output lbdc_head_type      head
);

   lbdc_item_type slot_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;

   assign full       = count_ff[1];
   assign head.valid = (count_ff != 2'd0);
   assign head.item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

// ===== src/lbdc_back.sv =====
// back end: pipelined restoring divider, one quotient bit per stage
`default_nettype none
module lbdc_back
   import lbdc_pkg::*;
#(
   parameter int TOTAL_ENTRIES = 1712
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire lbdc_head_type head,
   output logic               pop,
   output logic               out_valid,
   input  wire logic          out_ready,
   output lbdc_item_type      out_item,
   output logic [LINES_W-1:0] out_lines
);

   localparam int NUM_W = $clog2(TOTAL_ENTRIES + 1);
   localparam logic [NUM_W-1:0] NUM = NUM_W'(TOTAL_ENTRIES);

   logic                 adv;
   logic [NUM_W:0]       vld_ff;
   lbdc_item_type        item_ff [NUM_W+1];
   logic [PITCH_W-1:0]   rem_ff  [NUM_W+1];
   logic [NUM_W-1:0]     quo_ff  [NUM_W+1];
   logic [PITCH_W-1:0]   rem_in  [NUM_W];
   logic [NUM_W-1:0]     quo_in  [NUM_W];
   logic [PITCH_W-1:0]   q_ext;

   // whole pipeline moves unless the last stage holds an untaken result
   assign adv = !vld_ff[NUM_W] || out_ready;
   assign pop = adv && head.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NUM_W-1:0], head.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         item_ff[0] <= head.item;
         rem_ff[0]  <= '0;
         quo_ff[0]  <= '0;
      end
   end

   for (genvar s = 0; s < NUM_W; s++) begin : g_stage
      logic [PITCH_W-1:0] dvs;
      logic [PITCH_W:0]   shifted;
      logic [PITCH_W:0]   diff;

      // a non-fitting item divides by one, its count is masked later
      assign dvs     = item_ff[s].fits ? item_ff[s].pitch : PITCH_W'(1);
      assign shifted = {rem_ff[s], NUM[NUM_W-1-s]};
      assign diff    = shifted - {1'b0, dvs};

      always_comb begin
         quo_in[s] = quo_ff[s];
         if (shifted >= {1'b0, dvs}) begin
            rem_in[s]             = diff[PITCH_W-1:0];
            quo_in[s][NUM_W-1-s]  = 1'b1;
         end else begin
            rem_in[s]             = shifted[PITCH_W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            item_ff[s+1] <= item_ff[s];
            rem_ff[s+1]  <= rem_in[s];
            quo_ff[s+1]  <= quo_in[s];
         end
      end
   end

   assign q_ext     = PITCH_W'(quo_ff[NUM_W]);
   assign out_valid = vld_ff[NUM_W];
   assign out_item  = item_ff[NUM_W];

   always_comb begin
      priority if (!item_ff[NUM_W].fits) begin
         out_lines = '0;
      end else if (q_ext > PITCH_W'(LINE_COUNT_MAX)) begin
         out_lines = LINE_COUNT_MAX;
      end else begin
         out_lines = q_ext[LINES_W-1:0];
      end
   end

endmodule
`default_nettype wire

// ===== src/line_buffer_depth_and_line_capacity_unit.sv =====
// top level of the line buffer depth and line capacity unit
//
//  channel | direction | beat contents
//  --------+-----------+----------------------------------------------------
//  req     | in        | color_depth, active_pixels
//  rsp     | out       | storage_depth, pitch_entries, line_count, fits
//  csr     | in        | write-only: depth_caps (0), default_depth (1)
//
// one beat per cycle sustained while rsp is not stalled; a result passes
// through the queue, then the divider pipeline that retires one quotient
// bit per stage
// reset is synchronous: it empties the queue and the divider pipeline and
// loads depth_caps = 4, default_depth = 2
// a stalled rsp freezes the divider; the two-entry queue keeps taking
// request beats until it fills
`default_nettype none
module line_buffer_depth_and_line_capacity_unit
   import lbdc_pkg::*;
#(
   parameter int TOTAL_ENTRIES = 1712
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [23:0]          req_tdata,   // color_depth[5:0], active_pixels[19:6]
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [31:0]               rsp_tdata,   // storage_depth[1:0], pitch_entries[14:2],
                                                  // line_count[25:15], fits[26]
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_addr,
   input  wire logic [CSR_DAT_W-1:0] csr_wdata
);

   logic [CAPS_W-1:0]  depth_caps_ff, depth_caps_in;
   logic [DEPTH_W-1:0] default_depth_ff, default_depth_in;

   lbdc_item_type      front_item;
   lbdc_item_type      back_item;
   lbdc_head_type      head;
   logic               q_full;
   logic               q_push;
   logic               q_pop;
   logic [LINES_W-1:0] back_lines;

   // config registers
   always_comb begin
      depth_caps_in    = depth_caps_ff;
      default_depth_in = default_depth_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_DEPTH_CAPS:    depth_caps_in    = csr_wdata[CAPS_W-1:0];
            CSR_DEFAULT_DEPTH: default_depth_in = csr_wdata[DEPTH_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_caps_ff    <= CAPS_RESET;
         default_depth_ff <= DEFAULT_RESET;
      end else begin
         depth_caps_ff    <= depth_caps_in;
         default_depth_ff <= default_depth_in;
      end
   end

   // front: classify the request beat in the cycle it arrives
   lbdc_front #(
      .TOTAL_ENTRIES (TOTAL_ENTRIES)
   ) u_front (
      .depth_caps    (depth_caps_ff),
      .default_depth (default_depth_ff),
      .color_depth   (req_tdata[BPP_W-1:0]),
      .active_pixels (req_tdata[BPP_W+WIDTH_W-1:BPP_W]),
      .item          (front_item)
   );

   // accept whenever the queue has a free slot
   assign req_tready = !q_full;
   assign q_push     = req_tvalid && req_tready;

   lbdc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (front_item),
      .full      (q_full),
      .pop       (q_pop),
      .head      (head)
   );

   // back: line count by pipelined division of the buffer size
   lbdc_back #(
      .TOTAL_ENTRIES (TOTAL_ENTRIES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (q_pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (back_item),
      .out_lines (back_lines)
   );

   assign rsp_tdata = {5'd0, back_item.fits, back_lines, back_item.pitch, back_item.depth};

endmodule
`default_nettype wire

// ===== src/lbdc_checker.sv =====
// port-level checks for the line buffer depth and line capacity unit
`default_nettype none
module lbdc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata
);

   // a result held back by the sink keeps its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");

   // a line that does not fit reports no lines
   a_nofit_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[26] |-> rsp_tdata[25:15] == 11'd0)
      else $error("line count set without fit");

   // a fitting line has a nonzero pitch and at least one line
   a_fit_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[26] |-> rsp_tdata[14:2] != 13'd0 && rsp_tdata[25:15] != 11'd0)
      else $error("fit reported with zero pitch or count");

   // the pipeline is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("result or full queue right after reset");

endmodule

bind line_buffer_depth_and_line_capacity_unit lbdc_checker u_lbdc_checker (.*);
`default_nettype wire
